// ===== design/multichannel_moving_average_top_defines.svh =====
// Assertion macros used by the moving average back end.
`ifndef MULTICHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_TOP_DEFINES_SVH

// Check a condition on every rising clock edge outside reset.
`define MMA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define MMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define MMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mma_pkg.sv =====
// Package with sizes, types and state codes of the moving average block.
`default_nettype none

package mma_pkg;

  localparam int WINDOW      = 16;
  localparam int CHANNELS    = 6;
  localparam int SAMPLE_BITS = 24;
  localparam int OUT_FIELDS  = 6;

  localparam int SLOT_BITS = $clog2(WINDOW);
  localparam int FILL_BITS = $clog2(WINDOW + 1);
  localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int MAG_BITS  = SUM_BITS;

  localparam int DIV_RADIX    = 4;
  localparam int DIV_STEPS    = (MAG_BITS + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_BITS     = DIV_STEPS * DIV_RADIX;
  localparam int DIV_CNT_BITS = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0] sum_t;
  typedef logic [FILL_BITS-1:0] fill_t;
  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] row_t;

  typedef struct packed {
    logic valid;
    row_t samples;
  } item_t;

  typedef struct packed {
    logic valid;
    row_t avg;
  } result_t;

  typedef struct packed {
    logic                start;
    logic                neg;
    logic [MAG_BITS-1:0] mag;
    fill_t               divisor;
  } div_req_t;

  typedef struct packed {
    logic    busy;
    logic    done;
    sample_t quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== design/mma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== design/mma_div.sv =====
// Iterative unsigned-magnitude divider, four quotient bits per cycle.
`default_nettype none

module mma_div
  import mma_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                    busy_r;
  logic                    done_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    neg_r;
  fill_t                   div_r;
  fill_t                   rem_r;
  logic [DIV_BITS-1:0]     quo_r;

  fill_t                   rem_v;
  logic [DIV_BITS-1:0]     quo_v;
  logic [FILL_BITS:0]      trial;
  logic [DIV_BITS-1:0]     signed_q;

  // Run DIV_RADIX restoring steps on the narrow remainder.
  always_comb begin
    rem_v = rem_r;
    quo_v = quo_r;
    trial = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      trial = {rem_v, quo_v[DIV_BITS-1]};
      quo_v = {quo_v[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_v    = FILL_BITS'(trial - {1'b0, div_r});
        quo_v[0] = 1'b1;
      end else begin
        rem_v = trial[FILL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_BITS'(DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.neg;
      div_r <= req.divisor;
      rem_r <= '0;
      quo_r <= DIV_BITS'(req.mag);
    end else if (busy_r) begin
      rem_r <= rem_v;
      quo_r <= quo_v;
    end
  end

  assign signed_q = neg_r ? (DIV_BITS'(0) - quo_r) : quo_r;

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = signed_q[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ===== design/mma_front.sv =====
// Input queue that takes sample words and hands them to the back end.
`default_nettype none

module mma_front
  import mma_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire row_t in_row,
  output logic      full,
  output item_t     item,
  input  wire logic pop
);

  row_t                 entry_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;
  logic                 do_wr;
  logic                 do_rd;

  assign full  = (count_r == QCNT_BITS'(QDEPTH));
  assign do_wr = push && !full;
  assign do_rd = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= in_row;
    end
  end

  assign item.valid   = (count_r != '0);
  assign item.samples = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== design/mma_back.sv =====
// Back end: window store, running sums, shared divider and result register.
`default_nettype none

`include "multichannel_moving_average_top_defines.svh"

module mma_back
  import mma_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire item_t item,
  output logic       item_pop,
  input  wire logic  out_pop,
  output result_t    result
);

  back_state_t          state_r;
  back_state_t          state_nxt;
  fill_t                fill_r;
  logic [SLOT_BITS-1:0] slot_r;
  logic [CH_BITS-1:0]   ch_r;
  sum_t                 sums_r [CHANNELS];
  logic                 out_valid_r;

  row_t                 row_r;
  row_t                 old_row_r;
  row_t                 res_r;
  row_t                 out_row_r;

  row_t                 ram_rdata;
  logic                 ram_we;
  logic                 div_start;
  div_req_t             div_req;
  div_rsp_t             div_rsp;
  sum_t                 sum_new;
  logic                 last_ch;

  mma_ram #(
    .WIDTH(CHANNELS * SAMPLE_BITS),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(row_r),
    .raddr(slot_r),
    .rdata(ram_rdata)
  );

  mma_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign last_ch = (ch_r == CH_BITS'(CHANNELS - 1));
  assign sum_new = sums_r[ch_r] - sum_t'($signed(old_row_r[ch_r]))
                 + sum_t'($signed(row_r[ch_r]));

  always_comb begin
    div_req.start   = div_start;
    div_req.neg     = sum_new[SUM_BITS-1];
    div_req.mag     = sum_new[SUM_BITS-1] ? MAG_BITS'(-sum_new) : MAG_BITS'(sum_new);
    div_req.divisor = fill_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (item.valid) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = last_ch ? ST_DONE : ST_CALC;
        end
      end
      ST_DONE: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop  = 1'b0;
    div_start = 1'b0;
    ram_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: item_pop = item.valid;
      ST_CALC: div_start = 1'b1;
      ST_DONE: ram_we = !out_valid_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      slot_r      <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_READ) begin
        ch_r <= '0;
        if (fill_r < fill_t'(WINDOW)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (state_r == ST_CALC) begin
        sums_r[ch_r] <= sum_new;
      end
      if (state_r == ST_DIV && div_rsp.done && !last_ch) begin
        ch_r <= ch_r + 1'b1;
      end
      if (ram_we) begin
        slot_r <= (slot_r == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      end
      if (ram_we) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slots not yet written during warm-up read as zero.
  always_ff @(posedge clk) begin
    if (item_pop) begin
      row_r <= item.samples;
    end
    if (state_r == ST_READ) begin
      old_row_r <= (fill_r < fill_t'(WINDOW)) ? '0 : ram_rdata;
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      res_r[ch_r] <= div_rsp.quotient;
    end
    if (ram_we) begin
      out_row_r <= res_r;
    end
  end

  assign result.valid = out_valid_r;
  assign result.avg   = out_row_r;

  `MMA_ASSERT_ALWAYS(a_fill_bounded, clk, rst_n, fill_r <= fill_t'(WINDOW), "fill count past window")
  `MMA_ASSERT_IMPLY(a_div_free_on_start, clk, rst_n, state_r == ST_CALC, !div_rsp.busy && !div_rsp.done, "divider started while busy")
  `MMA_ASSERT_IMPLY(a_done_only_in_div, clk, rst_n, div_rsp.done, state_r == ST_DIV, "quotient arrived outside divide wait")
  `MMA_ASSERT_NEXT(a_write_sets_valid, clk, rst_n, ram_we, out_valid_r && slot_r != $past(slot_r), "result not posted with slot advance")

endmodule

`default_nettype wire

// ===== design/multichannel_moving_average_top.sv =====
// Top level of the six-channel boxcar moving average filter.
`default_nettype none

// Six-channel boxcar moving average over the last WINDOW (16) sample words,
// signed Q16.8 in and out. Push a word of six samples while full is low; one
// word of six averages appears on the out_ ports while empty is low and is
// taken with pop. During warm-up the divisor is the number of words seen so
// far, later it is WINDOW; quotients truncate toward zero. The back end takes
// one word at a time from the input queue and reads the window store; then,
// per channel, it updates the running sum and waits on the shared radix-16
// divider (seven steps and the hand-back); last it posts the result and
// writes the window slot, waiting until the result register is free. So the
// sustained rate is set by the single divider that serves all six channels
// in turn. A two-word input queue and the result register let either side
// stall on its own. The window store needs no clearing pass after reset:
// the fill count marks which slots are still empty.
module multichannel_moving_average_top
  import mma_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [SAMPLE_BITS-1:0] in_channel_0,
  input  wire logic [SAMPLE_BITS-1:0] in_channel_1,
  input  wire logic [SAMPLE_BITS-1:0] in_channel_2,
  input  wire logic [SAMPLE_BITS-1:0] in_channel_3,
  input  wire logic [SAMPLE_BITS-1:0] in_channel_4,
  input  wire logic [SAMPLE_BITS-1:0] in_channel_5,
  output logic                        empty,
  input  wire logic                   pop,
  output logic      [SAMPLE_BITS-1:0] out_average_0,
  output logic      [SAMPLE_BITS-1:0] out_average_1,
  output logic      [SAMPLE_BITS-1:0] out_average_2,
  output logic      [SAMPLE_BITS-1:0] out_average_3,
  output logic      [SAMPLE_BITS-1:0] out_average_4,
  output logic      [SAMPLE_BITS-1:0] out_average_5
);

  sample_t in_arr  [OUT_FIELDS];
  sample_t out_arr [OUT_FIELDS];
  row_t    in_row;
  item_t   item;
  logic    item_pop;
  result_t result;
  logic    out_pop;

  // Gather the input ports; drop channels beyond CHANNELS.
  always_comb begin
    in_arr[0] = in_channel_0;
    in_arr[1] = in_channel_1;
    in_arr[2] = in_channel_2;
    in_arr[3] = in_channel_3;
    in_arr[4] = in_channel_4;
    in_arr[5] = in_channel_5;
    in_row    = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      in_row[c] = in_arr[c];
    end
  end

  // Front end: hold incoming words until the back end takes them.
  mma_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .in_row(in_row),
    .full  (full),
    .item  (item),
    .pop   (item_pop)
  );

  // Advance the result register only on a real pop.
  assign out_pop = pop && result.valid;

  // Back end: window store, running sums, divider, result register.
  mma_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .item_pop(item_pop),
    .out_pop (out_pop),
    .result  (result)
  );

  assign empty = !result.valid;

  // Drive unused channels' averages to zero.
  always_comb begin
    for (int f = 0; f < OUT_FIELDS; f++) begin
      out_arr[f] = '0;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      out_arr[c] = result.avg[c];
    end
  end

  assign out_average_0 = out_arr[0];
  assign out_average_1 = out_arr[1];
  assign out_average_2 = out_arr[2];
  assign out_average_3 = out_arr[3];
  assign out_average_4 = out_arr[4];
  assign out_average_5 = out_arr[5];

endmodule

`default_nettype wire
